// ----- src/ipr_pkg.sv -----
// shared types and constants for the ip range lookup block
package ipr_pkg;

    localparam int ADDR_W  = 32;
    localparam int WIDX_W  = 10;
    localparam int CFG_W   = 11;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W  = 1;
    localparam int QCNT_W  = 2;

    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_LOOKUP = 1'b1;

    typedef struct packed {
        logic              op;
        logic [WIDX_W-1:0] widx;
        logic [ADDR_W-1:0] d_low;
        logic [ADDR_W-1:0] d_high;
    } t_item;

    typedef struct packed {
        logic  valid;
        t_item item;
    } t_queue_head;

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_PROBE = 3'b010,
        S_EMIT  = 3'b100
    } t_state;

endpackage

// ----- src/ipr_queue.sv -----
// short item queue between the front and the search engine
module ipr_queue (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  ipr_pkg::t_item       i_item,
    input  logic                 i_pop,
    output logic                 o_full,
    output ipr_pkg::t_queue_head o_head
);
    import ipr_pkg::*;

    t_item              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  r_wr_ptr, n_wr_ptr;
    logic [QPTR_W-1:0]  r_rd_ptr, n_rd_ptr;
    logic [QCNT_W-1:0]  r_count, n_count;
    logic               push_ok;
    logic               pop_ok;

    assign push_ok = i_push && (r_count != QCNT_W'(QUEUE_DEPTH));
    assign pop_ok  = i_pop && (r_count != '0);

    always_comb begin
        n_wr_ptr = push_ok ? r_wr_ptr + 1'b1 : r_wr_ptr;
        n_rd_ptr = pop_ok ? r_rd_ptr + 1'b1 : r_rd_ptr;
        n_count  = r_count;
        if (push_ok && !pop_ok) begin
            n_count = r_count + 1'b1;
        end else if (!push_ok && pop_ok) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    assign o_full       = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_head.valid = (r_count != '0);
    assign o_head.item  = r_mem[r_rd_ptr];

endmodule

// ----- src/ipr_front.sv -----
// input acceptance and item classification
module ipr_front #(
    parameter int TABLE_DEPTH = 1024
) (
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic                        i_operation,
    input  logic [ipr_pkg::WIDX_W-1:0]  i_write_index,
    input  logic [ipr_pkg::ADDR_W-1:0]  i_new_low,
    input  logic [ipr_pkg::ADDR_W-1:0]  i_new_high,
    input  logic [ipr_pkg::ADDR_W-1:0]  i_lookup_addr,
    input  logic                        i_q_full,
    output logic                        o_q_push,
    output ipr_pkg::t_item              o_q_item
);
    import ipr_pkg::*;

    logic keep;

    // writes outside the table are taken and dropped
    assign keep = (i_operation == OP_LOOKUP) ||
                  (32'(i_write_index) < 32'(TABLE_DEPTH));

    assign o_in_ready = !i_q_full;
    assign o_q_push   = i_in_valid && !i_q_full && keep;

    always_comb begin
        o_q_item.op   = i_operation;
        o_q_item.widx = i_write_index;
        if (i_operation == OP_LOOKUP) begin
            o_q_item.d_low  = i_lookup_addr;
            o_q_item.d_high = '0;
        end else begin
            o_q_item.d_low  = i_new_low;
            o_q_item.d_high = i_new_high;
        end
    end

endmodule

// ----- src/ipr_search.sv -----
// range table memory and binary search engine with output register
module ipr_search #(
    parameter int TABLE_DEPTH = 1024
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [ipr_pkg::CFG_W-1:0]   i_entries_used,
    input  ipr_pkg::t_queue_head        i_head,
    output logic                        o_q_pop,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic                        o_found,
    output logic [ipr_pkg::WIDX_W-1:0]  o_match_index,
    output logic [ipr_pkg::ADDR_W-1:0]  o_match_low,
    output logic [ipr_pkg::ADDR_W-1:0]  o_match_high
);
    import ipr_pkg::*;

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    logic [2*ADDR_W-1:0] mem [TABLE_DEPTH];

    t_state              r_state, n_state;
    logic [CW-1:0]       r_lo, n_lo;
    logic [CW-1:0]       r_n, n_n;
    logic [AW-1:0]       r_mid, n_mid;
    logic [ADDR_W-1:0]   r_addr, n_addr;
    logic                r_found, n_found;
    logic [ADDR_W-1:0]   r_rd_low;
    logic [ADDR_W-1:0]   r_rd_high;
    logic                r_out_valid, n_out_valid;
    logic                r_out_found, n_out_found;
    logic [WIDX_W-1:0]   r_out_index, n_out_index;
    logic [ADDR_W-1:0]   r_out_low, n_out_low;
    logic [ADDR_W-1:0]   r_out_high, n_out_high;

    logic                mem_we;
    logic [AW-1:0]       mem_waddr;
    logic                mem_re;
    logic [AW-1:0]       mem_raddr;
    logic [CW-1:0]       n_start;
    logic                below;
    logic                above;
    logic [CW-1:0]       step_lo;
    logic [CW-1:0]       step_n;
    logic [CW-1:0]       step_mid;
    logic                slot_free;

    assign slot_free = !r_out_valid || i_out_ready;
    assign below     = r_addr < r_rd_low;
    assign above     = r_addr > r_rd_high;

    always_comb begin
        if (32'(i_entries_used) > 32'(TABLE_DEPTH)) begin
            n_start = CW'(TABLE_DEPTH);
        end else begin
            n_start = CW'(i_entries_used);
        end
        if (below) begin
            step_lo = r_lo;
            step_n  = r_n >> 1;
        end else begin
            step_lo = CW'(r_mid) + 1'b1;
            step_n  = r_n - (r_n >> 1) - 1'b1;
        end
        step_mid = step_lo + (step_n >> 1);
    end

    always_comb begin
        n_state     = r_state;
        n_lo        = r_lo;
        n_n         = r_n;
        n_mid       = r_mid;
        n_addr      = r_addr;
        n_found     = r_found;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out_found = r_out_found;
        n_out_index = r_out_index;
        n_out_low   = r_out_low;
        n_out_high  = r_out_high;
        o_q_pop     = 1'b0;
        mem_we      = 1'b0;
        mem_waddr   = AW'(i_head.item.widx);
        mem_re      = 1'b0;
        mem_raddr   = AW'(n_start >> 1);
        case (r_state)
            S_IDLE: begin
                if (i_head.valid) begin
                    o_q_pop = 1'b1;
                    if (i_head.item.op == OP_WRITE) begin
                        mem_we = 1'b1;
                    end else begin
                        n_addr  = i_head.item.d_low;
                        n_lo    = '0;
                        n_n     = n_start;
                        n_mid   = AW'(n_start >> 1);
                        n_found = 1'b0;
                        if (n_start == '0) begin
                            n_state = S_EMIT;
                        end else begin
                            mem_re  = 1'b1;
                            n_state = S_PROBE;
                        end
                    end
                end
            end
            S_PROBE: begin
                mem_raddr = AW'(step_mid);
                if (!below && !above) begin
                    n_found = 1'b1;
                    n_state = S_EMIT;
                end else if (step_n == '0) begin
                    n_found = 1'b0;
                    n_state = S_EMIT;
                end else begin
                    n_lo    = step_lo;
                    n_n     = step_n;
                    n_mid   = AW'(step_mid);
                    mem_re  = 1'b1;
                end
            end
            S_EMIT: begin
                if (slot_free) begin
                    n_out_valid = 1'b1;
                    n_out_found = r_found;
                    n_out_index = r_found ? WIDX_W'(r_mid) : '0;
                    n_out_low   = r_found ? r_rd_low : '0;
                    n_out_high  = r_found ? r_rd_high : '0;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lo        <= n_lo;
        r_n         <= n_n;
        r_mid       <= n_mid;
        r_addr      <= n_addr;
        r_found     <= n_found;
        r_out_found <= n_out_found;
        r_out_index <= n_out_index;
        r_out_low   <= n_out_low;
        r_out_high  <= n_out_high;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= {i_head.item.d_low, i_head.item.d_high};
        end
        if (mem_re) begin
            {r_rd_low, r_rd_high} <= mem[mem_raddr];
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_found       = r_out_found;
    assign o_match_index = r_out_index;
    assign o_match_low   = r_out_low;
    assign o_match_high  = r_out_high;

    a_probe_span_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PROBE) |-> (r_n != '0))
        else $error("probe on empty span");

    a_probe_span_in_table: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PROBE) |-> (32'(r_lo) + 32'(r_n) <= 32'(TABLE_DEPTH)))
        else $error("search span leaves the table");

    a_probe_mid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PROBE) |-> (32'(r_mid) == 32'(r_lo) + 32'(r_n >> 1)))
        else $error("probe position off span center");

    a_pop_only_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_pop |-> (r_state == S_IDLE) && i_head.valid)
        else $error("queue pop outside idle");

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_found) |->
            (r_out_index == '0) && (r_out_low == '0) && (r_out_high == '0))
        else $error("miss result carries nonzero fields");

endmodule

// ----- src/ip_range_binary_lookup.sv -----
// top level of the ip range table with binary search lookup
// Usage:
//   input channel (i_in_valid / o_in_ready): one transfer is a write item
//   (i_operation 0, stores i_new_low..i_new_high at i_write_index) or a
//   lookup item (i_operation 1, searches i_lookup_addr).
//   output channel (o_out_valid / i_out_ready): one transfer per lookup,
//   none per write; o_found with index and bounds, zeros on a miss.
//   config channel (i_cfg_valid / o_cfg_ready): sets entries_used, the
//   span searched; write it only while the block is idle.
// Steps: the search engine stores a write from the queue head as it pops it. A lookup
//   makes p probes, at most log2(TABLE_DEPTH) + 1 (11 at 1024), one probe a cycle
//   through the single read port of the range memory, then fills the output register.
//   Items wait in a two-entry queue, so input is taken during a search until it fills.
// Reset clears entries_used, the queue, the search state and the output valid
//   flag; table contents stay undefined until written, no clearing.
// A stalled receiver holds the result in the output register; the engine
//   then waits in its emit step and the queue fills before o_in_ready drops.
module ip_range_binary_lookup #(
    parameter int TABLE_DEPTH = 1024
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic                        i_operation,
    input  logic [ipr_pkg::WIDX_W-1:0]  i_write_index,
    input  logic [ipr_pkg::ADDR_W-1:0]  i_new_low,
    input  logic [ipr_pkg::ADDR_W-1:0]  i_new_high,
    input  logic [ipr_pkg::ADDR_W-1:0]  i_lookup_addr,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic                        o_found,
    output logic [ipr_pkg::WIDX_W-1:0]  o_match_index,
    output logic [ipr_pkg::ADDR_W-1:0]  o_match_low,
    output logic [ipr_pkg::ADDR_W-1:0]  o_match_high,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [ipr_pkg::CFG_W-1:0]   i_cfg_entries_used
);
    import ipr_pkg::*;

    logic [CFG_W-1:0] r_entries_used;
    logic             q_full;
    logic             q_push;
    logic             q_pop;
    t_item            q_item;
    t_queue_head      q_head;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entries_used <= '0;
        end else if (i_cfg_valid) begin
            r_entries_used <= i_cfg_entries_used;
        end
    end

    ipr_front #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_front (
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_operation   (i_operation),
        .i_write_index (i_write_index),
        .i_new_low     (i_new_low),
        .i_new_high    (i_new_high),
        .i_lookup_addr (i_lookup_addr),
        .i_q_full      (q_full),
        .o_q_push      (q_push),
        .o_q_item      (q_item)
    );

    ipr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_item  (q_item),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_head  (q_head)
    );

    ipr_search #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_search (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_entries_used (r_entries_used),
        .i_head         (q_head),
        .o_q_pop        (q_pop),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_found        (o_found),
        .o_match_index  (o_match_index),
        .o_match_low    (o_match_low),
        .o_match_high   (o_match_high)
    );

endmodule

// ----- tb/sv/tb_ip_range_binary_lookup.sv -----
// self-checking testbench for the ip range binary lookup block
`timescale 1ns / 1ps

module tb_ip_range_binary_lookup;
    import ipr_pkg::*;

    localparam int DEPTH         = 1024;
    localparam int SLOT_BITS     = 22;
    localparam int SETTLE_CYCLES = 40;
    localparam int STALL_LIMIT   = 5000;
    localparam int MAX_PRINTED   = 30;

    typedef struct packed {
        logic              found;
        logic [WIDX_W-1:0] index;
        logic [ADDR_W-1:0] low;
        logic [ADDR_W-1:0] high;
    } t_match;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_in_valid;
    logic              o_in_ready;
    logic              i_operation;
    logic [WIDX_W-1:0] i_write_index;
    logic [ADDR_W-1:0] i_new_low;
    logic [ADDR_W-1:0] i_new_high;
    logic [ADDR_W-1:0] i_lookup_addr;
    logic              o_out_valid;
    logic              i_out_ready;
    logic              o_found;
    logic [WIDX_W-1:0] o_match_index;
    logic [ADDR_W-1:0] o_match_low;
    logic [ADDR_W-1:0] o_match_high;
    logic              i_cfg_valid;
    logic              o_cfg_ready;
    logic [CFG_W-1:0]  i_cfg_entries_used;

    // local copy of the range table and the search span
    logic [ADDR_W-1:0] range_low [DEPTH];
    logic [ADDR_W-1:0] range_high [DEPTH];
    logic [CFG_W-1:0]  span_limit;
    t_match            pending_matches [$];

    int tx_idle_pct   = 0;
    int rx_idle_pct   = 0;
    int rx_hold_left  = 0;
    int idle_cycles   = 0;
    int error_count   = 0;
    int lookup_count  = 0;
    int hit_count     = 0;
    int write_count   = 0;
    int cfg_count     = 0;

    ip_range_binary_lookup #(
        .TABLE_DEPTH(DEPTH)
    ) uut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_ready         (o_in_ready),
        .i_operation        (i_operation),
        .i_write_index      (i_write_index),
        .i_new_low          (i_new_low),
        .i_new_high         (i_new_high),
        .i_lookup_addr      (i_lookup_addr),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_found            (o_found),
        .o_match_index      (o_match_index),
        .o_match_low        (o_match_low),
        .o_match_high       (o_match_high),
        .i_cfg_valid        (i_cfg_valid),
        .o_cfg_ready        (o_cfg_ready),
        .i_cfg_entries_used (i_cfg_entries_used)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic t_match search_ranges(logic [ADDR_W-1:0] addr);
        int unsigned base;
        int unsigned span;
        int unsigned mid;
        t_match      hit;
        hit  = '0;
        base = 0;
        span = (span_limit > DEPTH) ? DEPTH : span_limit;
        while (span > 0) begin
            mid = base + span / 2;
            if (addr < range_low[mid]) begin
                span = span / 2;
            end else if (addr > range_high[mid]) begin
                base = mid + 1;
                span = span - span / 2 - 1;
            end else begin
                hit.found = 1'b1;
                hit.index = mid[WIDX_W-1:0];
                hit.low   = range_low[mid];
                hit.high  = range_high[mid];
                span      = 0;
            end
        end
        return hit;
    endfunction

    task automatic report_mismatch(string what, logic [ADDR_W-1:0] got,
                                   logic [ADDR_W-1:0] want);
        if (error_count < MAX_PRINTED) begin
            $display("mismatch at %0t: %s got %h expected %h", $time, what, got, want);
        end
        error_count++;
    endtask

    // predictor and result checker, both on the rising edge
    always @(posedge i_clk) begin
        t_match want;
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) begin
                span_limit = i_cfg_entries_used;
                cfg_count++;
            end
            if (i_in_valid && o_in_ready) begin
                if (i_operation == OP_WRITE) begin
                    range_low[i_write_index]  = i_new_low;
                    range_high[i_write_index] = i_new_high;
                    write_count++;
                end else begin
                    want = search_ranges(i_lookup_addr);
                    pending_matches.push_back(want);
                    lookup_count++;
                    if (want.found) begin
                        hit_count++;
                    end
                end
            end
            if (o_out_valid && i_out_ready) begin
                if (pending_matches.size() == 0) begin
                    report_mismatch("result with no lookup pending, found",
                                    ADDR_W'(o_found), '0);
                end else begin
                    want = pending_matches.pop_front();
                    if (o_found !== want.found) begin
                        report_mismatch("found", ADDR_W'(o_found), ADDR_W'(want.found));
                    end
                    if (o_match_index !== want.index) begin
                        report_mismatch("match_index", ADDR_W'(o_match_index),
                                        ADDR_W'(want.index));
                    end
                    if (o_match_low !== want.low) begin
                        report_mismatch("match_low", o_match_low, want.low);
                    end
                    if (o_match_high !== want.high) begin
                        report_mismatch("match_high", o_match_high, want.high);
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
                || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles", idle_cycles);
            $display("simulation failed");
            $finish;
        end
    end

    // result side: random stalls plus an optional long hold-off
    initial begin
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (rx_hold_left > 0) begin
                i_out_ready <= 1'b0;
                rx_hold_left--;
            end else begin
                i_out_ready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    task automatic set_idling(int tx_pct, int rx_pct);
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
    endtask

    // starts and ends on a falling edge, leaves valid high after the transfer
    task automatic send_item(logic op, logic [WIDX_W-1:0] widx, logic [ADDR_W-1:0] lo,
                             logic [ADDR_W-1:0] hi, logic [ADDR_W-1:0] addr);
        int gap;
        gap = 0;
        while ($urandom_range(99) < tx_idle_pct) begin
            gap++;
        end
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_operation   <= op;
        i_write_index <= widx;
        i_new_low     <= lo;
        i_new_high    <= hi;
        i_lookup_addr <= addr;
        @(posedge i_clk);
        while (!o_in_ready) begin
            @(posedge i_clk);
        end
        @(negedge i_clk);
    endtask

    task automatic send_write(logic [WIDX_W-1:0] widx, logic [ADDR_W-1:0] lo,
                              logic [ADDR_W-1:0] hi);
        send_item(OP_WRITE, widx, lo, hi, $urandom);
    endtask

    task automatic send_lookup(logic [ADDR_W-1:0] addr);
        send_item(OP_LOOKUP, WIDX_W'($urandom), $urandom, $urandom, addr);
    endtask

    // drop valid, let every result arrive and the engine finish any write
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (pending_matches.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic set_entries_used(logic [CFG_W-1:0] value);
        wait_idle();
        i_cfg_valid        <= 1'b1;
        i_cfg_entries_used <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) begin
            @(posedge i_clk);
        end
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // each entry lives in its own slice of the address space, keeping the table sorted
    task automatic write_sorted_entry(int unsigned k);
        logic [ADDR_W-1:0] base;
        logic [ADDR_W-1:0] lo;
        logic [ADDR_W-1:0] hi;
        base = k << SLOT_BITS;
        lo   = base + $urandom_range(1 << (SLOT_BITS - 1), 0);
        hi   = lo + $urandom_range((1 << SLOT_BITS) - 1 - (lo - base), 0);
        send_write(k[WIDX_W-1:0], lo, hi);
    endtask

    // mostly addresses inside or at the edges of searched ranges
    function automatic logic [ADDR_W-1:0] probe_address();
        int unsigned       n;
        int unsigned       k;
        logic [ADDR_W-1:0] lo;
        logic [ADDR_W-1:0] hi;
        logic [ADDR_W-1:0] offset;
        longint unsigned   width;
        n = (span_limit > DEPTH) ? DEPTH : span_limit;
        if (n == 0) begin
            return $urandom;
        end
        k  = $urandom_range(n - 1, 0);
        lo = range_low[k];
        hi = range_high[k];
        case ($urandom_range(9))
            0: return lo - 1;
            1: return lo;
            2: return hi;
            3: return hi + 1;
            4, 5, 6: return $urandom;
            default: begin
                if (lo > hi) begin
                    return $urandom;
                end
                width  = {32'b0, hi} - {32'b0, lo} + 1;
                offset = ADDR_W'($urandom % width);
                return lo + offset;
            end
        endcase
    endfunction

    task automatic random_item();
        int unsigned pick;
        int unsigned k;
        pick = $urandom_range(99);
        k    = $urandom_range(DEPTH - 1, 0);
        if (pick < 14) begin
            write_sorted_entry(k);
        end else if (pick < 19) begin
            send_write(k[WIDX_W-1:0], $urandom, $urandom);
        end else begin
            send_lookup(probe_address());
        end
    endtask

    task automatic test_empty_table();
        set_idling(12, 72);
        set_entries_used('0);
        send_lookup(32'h0000_0000);
        send_lookup(32'hFFFF_FFFF);
        repeat (3) send_lookup($urandom);
    endtask

    task automatic test_small_table();
        logic [ADDR_W-1:0] addrs [12] = '{32'd9, 32'd10, 32'd20, 32'd25, 32'd30, 32'd31,
                                          32'd45, 32'd39, 32'd51, 32'h7FFF_FFFF,
                                          32'h8000_0000, 32'hFFFF_FFFF};
        send_write(WIDX_W'(0), 32'd10, 32'd20);
        send_write(WIDX_W'(1), 32'd30, 32'd30);
        // inverted range, never matches
        send_write(WIDX_W'(2), 32'd50, 32'd40);
        send_write(WIDX_W'(3), 32'h8000_0000, 32'hFFFF_FFFF);
        set_entries_used(CFG_W'(4));
        foreach (addrs[i]) begin
            send_lookup(addrs[i]);
        end
        set_entries_used(CFG_W'(1));
        send_lookup(32'd15);
        send_lookup(32'd30);
    endtask

    task automatic test_table_load();
        set_idling(12, 72);
        for (int k = 0; k < DEPTH; k++) begin
            write_sorted_entry(k);
        end
        send_write(WIDX_W'(0), 32'h0000_0000, range_high[0]);
        send_write(WIDX_W'(DEPTH - 1), range_low[DEPTH - 1], 32'hFFFF_FFFF);
        set_entries_used(CFG_W'(DEPTH));
        send_lookup(32'h0000_0000);
        send_lookup(32'hFFFF_FFFF);
        repeat (20) send_lookup(probe_address());
        // above the table depth, search is clipped to the full table
        set_entries_used({CFG_W{1'b1}});
        repeat (20) send_lookup(probe_address());
    endtask

    task automatic test_random();
        logic [CFG_W-1:0] used;
        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: set_idling(12, 72);
                1: set_idling(72, 12);
                default: set_idling(0, 0);
            endcase
            repeat (3) begin
                case ($urandom_range(6))
                    0: used = '0;
                    1: used = CFG_W'(1);
                    2: used = CFG_W'(DEPTH - 1);
                    3: used = CFG_W'(DEPTH);
                    4: used = {CFG_W{1'b1}};
                    default: used = CFG_W'($urandom_range(DEPTH, 2));
                endcase
                set_entries_used(used);
                repeat (10) random_item();
            end
        end
    endtask

    task automatic test_backpressure();
        set_idling(0, 0);
        set_entries_used(CFG_W'(DEPTH));
        rx_hold_left = 300;
        repeat (12) send_lookup(probe_address());
    endtask

    initial begin
        i_rst_n            = 1'b0;
        i_in_valid         = 1'b0;
        i_operation        = OP_WRITE;
        i_write_index      = '0;
        i_new_low          = '0;
        i_new_high         = '0;
        i_lookup_addr      = '0;
        i_cfg_valid        = 1'b0;
        i_cfg_entries_used = '0;
        span_limit         = '0;
        for (int k = 0; k < DEPTH; k++) begin
            range_low[k]  = '0;
            range_high[k] = '0;
        end
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_table();
        test_small_table();
        test_table_load();
        test_random();
        test_backpressure();
        wait_idle();

        $display("covered %0d lookups (%0d hits), %0d table writes, %0d register writes",
                 lookup_count, hit_count, write_count, cfg_count);
        $display("span settings from empty to clipped, three idling mixes and a long hold-off");
        if (error_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
src/ipr_pkg.sv
src/ipr_queue.sv
src/ipr_front.sv
src/ipr_search.sv
src/ip_range_binary_lookup.sv
tb/sv/tb_ip_range_binary_lookup.sv
